### rtl/hrm_pkg.sv
// Shared types and constants for the high-ROM cartridge mapper.
// No dependencies; hrm_cfg, the top level and the testbench refer to it by scoped names.
package hrm_pkg;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_LOCKED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BYTES  = 2'd2;

  localparam int ROM_SIZE_W = 23;
  localparam int RAM_SIZE_W = 18;
  localparam int RAM_OFF_W  = 20;

  // Reset value of the ROM size register.
  localparam logic [ROM_SIZE_W-1:0] ROM_BYTES_RESET = 23'h100000;

  // Address decode constants.
  localparam logic [6:0]  BANK_MASK      = 7'h7f;
  localparam logic [6:0]  WIN_A_BANK_LO  = 7'h30;
  localparam logic [6:0]  WIN_A_BANK_HI  = 7'h3f;
  localparam logic [15:0] WIN_A_OFF_MASK = 16'he000;
  localparam logic [15:0] WIN_A_OFF_BASE = 16'h6000;
  localparam logic [7:0]  WIN_B_BANK_LO  = 8'h70;
  localparam logic [7:0]  WIN_B_BANK_HI  = 8'h7d;

  // Mapping derived from the configuration registers.
  typedef struct packed {
    logic                  rom_locked;
    logic                  rom_split;    // a second, smaller chip is present
    logic [ROM_SIZE_W-1:0] rom_p0;       // size of the first chip
    logic [ROM_SIZE_W-1:0] rom_span;     // mask of the whole ROM span
    logic [ROM_SIZE_W-1:0] rom_p1m;      // size of the second chip minus one
    logic                  ram_present;
    logic [RAM_SIZE_W-1:0] ram_mask;
  } hrm_map_t;

endpackage

### rtl/hrm_if.sv
// Valid/ready channel interfaces for the bus access and result items.
// Depends on nothing but the fixed field widths of the mapper.
interface hrm_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [23:0] bus_address;
  logic [7:0]  write_byte;

  modport source (output valid, output operation, output bus_address, output write_byte,
                  input ready);
  modport sink   (input valid, input operation, input bus_address, input write_byte,
                  output ready);
endinterface

interface hrm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

### rtl/hrm_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No package dependency.
module hrm_ram #(
  parameter int WIDTH     = 8,
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/hrm_cfg.sv
// Configuration registers of the mapper and the ROM/RAM layout derived from them.
// Depends on hrm_pkg.
module hrm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [hrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output hrm_pkg::hrm_map_t                  map
);

  hrm_pkg::hrm_map_t map_r, map_nxt;

  logic [hrm_pkg::ROM_SIZE_W-1:0] rom_v;
  logic [hrm_pkg::ROM_SIZE_W-1:0] smear;
  logic [hrm_pkg::ROM_SIZE_W-1:0] p0;
  logic [hrm_pkg::ROM_SIZE_W-1:0] p1;
  logic [hrm_pkg::RAM_SIZE_W-1:0] ram_v;

  always_comb begin
    rom_v = cfg_wdata[hrm_pkg::ROM_SIZE_W-1:0];
    ram_v = cfg_wdata[hrm_pkg::RAM_SIZE_W-1:0];
    // Smear the highest set bit downward; its top bit alone is the first chip.
    smear = rom_v;
    smear = smear | (smear >> 1);
    smear = smear | (smear >> 2);
    smear = smear | (smear >> 4);
    smear = smear | (smear >> 8);
    smear = smear | (smear >> 16);
    if (rom_v == '0) begin
      p0 = hrm_pkg::ROM_SIZE_W'(1);
    end else begin
      p0 = smear & ~(smear >> 1);
    end
    p1 = rom_v & ~p0;

    map_nxt = map_r;
    if (cfg_we) begin
      unique case (cfg_index)
        hrm_pkg::CFG_ROM_LOCKED: map_nxt.rom_locked = cfg_wdata[0];
        hrm_pkg::CFG_ROM_BYTES: begin
          map_nxt.rom_p0    = p0;
          map_nxt.rom_split = (p1 != '0);
          map_nxt.rom_p1m   = p1 - hrm_pkg::ROM_SIZE_W'(1);
          map_nxt.rom_span  = (p1 != '0) ? ((p0 - hrm_pkg::ROM_SIZE_W'(1)) | p0)
                                         : (p0 - hrm_pkg::ROM_SIZE_W'(1));
        end
        hrm_pkg::CFG_RAM_BYTES: begin
          map_nxt.ram_present = (ram_v != '0);
          map_nxt.ram_mask    = ram_v - hrm_pkg::RAM_SIZE_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_r.rom_locked  <= 1'b1;
      map_r.rom_split   <= 1'b0;
      map_r.rom_p0      <= hrm_pkg::ROM_BYTES_RESET;
      map_r.rom_span    <= hrm_pkg::ROM_BYTES_RESET - hrm_pkg::ROM_SIZE_W'(1);
      map_r.rom_p1m     <= '1;
      map_r.ram_present <= 1'b0;
      map_r.ram_mask    <= '1;
    end else begin
      map_r <= map_nxt;
    end
  end

  assign map = map_r;

endmodule

### rtl/hirom_cartridge_mapper.sv
// Top level of the high-ROM cartridge mapper: decode, ROM and RAM arrays, result register.
// Depends on hrm_pkg, hrm_if, hrm_cfg and hrm_ram.
//
//   channel   direction  handshake     payload
//   in_bus    sink       valid/ready   operation, bus_address, write_byte
//   out_bus   source     valid/ready   read_byte
//   cfg_*     sink       cfg_we only   cfg_index, cfg_wdata
//
// One item per cycle while results are taken; each accepted item passes through the
// synchronous array read and then the result register before its result appears.
// Up to two items are in flight, one at the array port and one in the result register.
// A stalled result holds the array stage, which then holds the input.
// Reset is synchronous; the arrays are not cleared and need no sweep after reset.
module hirom_cartridge_mapper #(
  parameter int ROM_ADDR_BITS = 22,
  parameter int RAM_ADDR_BITS = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  hrm_in_if.sink                         in_bus,
  hrm_out_if.source                      out_bus,
  input  logic                           cfg_we,
  input  logic [hrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hrm_pkg::hrm_map_t map;

  hrm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .map      (map)
  );

  // Decode of the incoming item.
  logic [7:0]                       bank;
  logic [6:0]                       bank7;
  logic [15:0]                      offs;
  logic                             win_a;
  logic                             win_b;
  logic                             ram_hit;
  logic [hrm_pkg::RAM_OFF_W-1:0]    ram_off;
  logic [hrm_pkg::RAM_OFF_W-1:0]    ram_off_m;
  logic [hrm_pkg::ROM_SIZE_W-1:0]   rom_a;
  logic [hrm_pkg::ROM_SIZE_W-1:0]   rom_idx;
  logic [23:0]                      rom_idx24;
  logic                             accept;

  always_comb begin
    bank  = in_bus.bus_address[23:16];
    bank7 = bank[6:0] & hrm_pkg::BANK_MASK;
    offs  = in_bus.bus_address[15:0];
    win_a = (bank7 >= hrm_pkg::WIN_A_BANK_LO) && (bank7 <= hrm_pkg::WIN_A_BANK_HI)
            && ((offs & hrm_pkg::WIN_A_OFF_MASK) == hrm_pkg::WIN_A_OFF_BASE);
    win_b = (bank >= hrm_pkg::WIN_B_BANK_LO) && (bank <= hrm_pkg::WIN_B_BANK_HI);
    ram_hit = win_a || win_b;
    // Window A pages are 8 KiB, so the page number lands directly above the offset.
    if (win_a) begin
      ram_off = {3'b000, bank7[3:0], offs[12:0]};
    end else begin
      ram_off = {bank[3:0], offs};
    end
    ram_off_m = ram_off & {{(hrm_pkg::RAM_OFF_W - hrm_pkg::RAM_SIZE_W){1'b0}}, map.ram_mask};

    // An address in the upper half of a split ROM folds onto the second chip.
    rom_a = in_bus.bus_address[hrm_pkg::ROM_SIZE_W-1:0] & map.rom_span;
    if (map.rom_split && ((rom_a & map.rom_p0) != '0)) begin
      rom_idx = map.rom_p0 | (rom_a & map.rom_p1m);
    end else begin
      rom_idx = rom_a;
    end
    rom_idx24 = {1'b0, rom_idx};
  end

  // Array stage and result register.
  logic       p1_valid_r, p1_valid_nxt;
  logic       p1_zero_r;
  logic       p1_rom_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       p1_adv;
  logic [7:0] rom_q;
  logic [7:0] ram_q;

  assign p1_adv        = p1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready  = !p1_valid_r || p1_adv;
  assign accept        = in_bus.valid && in_bus.ready;
  assign p1_valid_nxt  = accept || (p1_valid_r && !p1_adv);
  assign out_valid_nxt = p1_adv || (out_valid_r && !out_bus.ready);

  logic rom_en, rom_we, ram_en, ram_we;

  always_comb begin
    rom_en = accept && !ram_hit && (!in_bus.operation || !map.rom_locked);
    rom_we = in_bus.operation;
    ram_en = accept && ram_hit && map.ram_present;
    ram_we = in_bus.operation;
  end

  hrm_ram #(.WIDTH(8), .ADDR_BITS(ROM_ADDR_BITS)) u_rom (
    .clk  (clk),
    .en   (rom_en),
    .we   (rom_we),
    .addr (rom_idx24[ROM_ADDR_BITS-1:0]),
    .wdata(in_bus.write_byte),
    .rdata(rom_q)
  );

  hrm_ram #(.WIDTH(8), .ADDR_BITS(RAM_ADDR_BITS)) u_ram (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_off_m[RAM_ADDR_BITS-1:0]),
    .wdata(in_bus.write_byte),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_zero_r <= in_bus.operation || (ram_hit && !map.ram_present);
      p1_rom_r  <= !ram_hit;
    end
    if (p1_adv) begin
      out_byte_r <= p1_zero_r ? 8'h00 : (p1_rom_r ? rom_q : ram_q);
    end
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_byte = out_byte_r;

endmodule

### rtl/hrm_checker.sv
// Port-level assertions for the high-ROM cartridge mapper, bound to its top level.
// Depends on hirom_cartridge_mapper and its channel interfaces.
module hrm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_operation,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_read_byte
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] cnt_r;
  logic [1:0] slot;
  logic       op_q_r [2];

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign slot    = cnt_r - {1'b0, out_acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  // Operation bits of the items in flight, oldest first.
  always_ff @(posedge clk) begin
    if (in_acc && (slot == 2'd0)) begin
      op_q_r[0] <= in_operation;
    end else if (out_acc) begin
      op_q_r[0] <= op_q_r[1];
    end
    if (in_acc && (slot != 2'd0)) begin
      op_q_r[1] <= in_operation;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte))
    else $error("result changed or vanished while stalled");

  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r <= 2'd2) && (!out_valid || (cnt_r != 2'd0)))
    else $error("result without a matching item, or more than two items in flight");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && op_q_r[0] |-> out_read_byte == 8'h00)
    else $error("result of a write item is not zero");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hirom_cartridge_mapper hrm_checker u_hrm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_bus.valid),
  .in_ready     (in_bus.ready),
  .in_operation (in_bus.operation),
  .out_valid    (out_bus.valid),
  .out_ready    (out_bus.ready),
  .out_read_byte(out_bus.read_byte)
);

### sim/tb_hirom_cartridge_mapper.sv
// Self-checking testbench for hirom_cartridge_mapper: random and directed bus accesses
// are checked against a behavioral map of ROM and battery RAM kept in the testbench.
// Depends on hrm_pkg, hrm_if and the mapper RTL.
module tb_hirom_cartridge_mapper;

  localparam int ROM_AW = 22;
  localparam int RAM_AW = 17;
  localparam int unsigned ROM_DEPTH = 32'd1 << ROM_AW;
  localparam int unsigned RAM_DEPTH = 32'd1 << RAM_AW;

  typedef enum logic {
    ACC_READ  = 1'b0,
    ACC_WRITE = 1'b1
  } acc_op_t;

  typedef struct {
    acc_op_t     op;
    logic [23:0] addr;
    logic [7:0]  data;
  } access_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [hrm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [hrm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  hrm_in_if  in_bus();
  hrm_out_if out_bus();

  hirom_cartridge_mapper #(
    .ROM_ADDR_BITS(ROM_AW),
    .RAM_ADDR_BITS(RAM_AW)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Mapping registers as the testbench believes them to be.
  logic        cfg_locked = 1'b1;
  logic [22:0] cfg_rom    = 23'h100000;
  logic [17:0] cfg_ram    = 18'h0;

  // Contents the mapper should hold, and the slots the stimulus has filled.
  logic [7:0] rom_img [int unsigned];
  logic [7:0] ram_img [int unsigned];
  bit rom_known [int unsigned];
  bit ram_known [int unsigned];
  logic [23:0] touched_q[$];

  access_t    pending_q[$];
  logic [7:0] read_bytes_q[$];

  logic in_busy = 1'b0;
  bit calm = 1'b0;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic log_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic int unsigned rom_slot(logic [23:0] addr);
    int unsigned p0, p1, span, a;
    if (cfg_rom == 0) begin
      p0 = 1;
      p1 = 0;
    end else begin
      p0 = 32'h800000;
      while ((cfg_rom & p0) == 0) p0 >>= 1;
      p1 = cfg_rom - p0;
    end
    span = (p1 == 0) ? p0 - 1 : 2 * p0 - 1;
    a = addr & span;
    // Addresses above the first chip land in the mirrored second chip.
    if (a >= p0 && p1 != 0) a = p0 + (a & (p1 - 1));
    return a & (ROM_DEPTH - 1);
  endfunction

  function automatic int unsigned ram_slot(int unsigned off);
    return (off & (int'(cfg_ram) - 1)) & (RAM_DEPTH - 1);
  endfunction

  function automatic bit ram_window(input logic [23:0] addr, output int unsigned off);
    logic [6:0]  bank7;
    logic [15:0] offs;
    bank7 = addr[22:16] & hrm_pkg::BANK_MASK;
    offs  = addr[15:0];
    off   = 0;
    if (bank7 >= hrm_pkg::WIN_A_BANK_LO && bank7 <= hrm_pkg::WIN_A_BANK_HI &&
        (offs & hrm_pkg::WIN_A_OFF_MASK) == hrm_pkg::WIN_A_OFF_BASE) begin
      off = (int'(bank7) - int'(hrm_pkg::WIN_A_BANK_LO)) * 32'h2000
            + (int'(offs) - int'(hrm_pkg::WIN_A_OFF_BASE));
      return 1'b1;
    end
    if (addr[23:16] >= hrm_pkg::WIN_B_BANK_LO && addr[23:16] <= hrm_pkg::WIN_B_BANK_HI) begin
      off = int'(addr) - 32'h700000;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one access to the expected memory image and returns the byte it reads.
  function automatic logic [7:0] expected_read(access_t acc);
    int unsigned off, slot;
    if (ram_window(acc.addr, off)) begin
      if (cfg_ram == 0) return 8'h00;
      slot = ram_slot(off);
      if (acc.op == ACC_WRITE) begin
        ram_img[slot] = acc.data;
        return 8'h00;
      end
      return ram_img.exists(slot) ? ram_img[slot] : 8'h00;
    end
    slot = rom_slot(acc.addr);
    if (acc.op == ACC_WRITE) begin
      if (!cfg_locked) rom_img[slot] = acc.data;
      return 8'h00;
    end
    return rom_img.exists(slot) ? rom_img[slot] : 8'h00;
  endfunction

  // A read is only issued where the slot behind it has been written, or RAM is absent.
  function automatic bit readable(logic [23:0] addr);
    int unsigned off;
    if (ram_window(addr, off)) return cfg_ram == 0 || ram_known.exists(ram_slot(off));
    return rom_known.exists(rom_slot(addr));
  endfunction

  task automatic queue_access(acc_op_t op, logic [23:0] addr, logic [7:0] data);
    access_t acc;
    int unsigned off;
    if (op == ACC_READ && !readable(addr)) op = ACC_WRITE;
    if (op == ACC_WRITE) begin
      if (ram_window(addr, off)) begin
        if (cfg_ram != 0) ram_known[ram_slot(off)] = 1'b1;
      end else if (!cfg_locked) begin
        rom_known[rom_slot(addr)] = 1'b1;
      end
      if (touched_q.size() < 400) touched_q.push_back(addr);
      else touched_q[$urandom_range(399)] = addr;
    end
    acc.op   = op;
    acc.addr = addr;
    acc.data = data;
    pending_q.push_back(acc);
  endtask

  function automatic logic [23:0] pick_address();
    int unsigned r;
    logic [7:0] bank;
    r = $urandom_range(99);
    if (r < 35) begin
      bank = {1'($urandom), 7'(hrm_pkg::WIN_A_BANK_LO + $urandom_range(15))};
      return {bank, 16'(hrm_pkg::WIN_A_OFF_BASE + $urandom_range(16'h1fff))};
    end
    if (r < 55) begin
      bank = 8'(hrm_pkg::WIN_B_BANK_LO
                + $urandom_range(hrm_pkg::WIN_B_BANK_HI - hrm_pkg::WIN_B_BANK_LO));
      return {bank, 16'($urandom)};
    end
    if (r < 65) begin
      // Just outside the RAM windows.
      case ($urandom_range(3))
        0: return {1'($urandom), 7'h2f + 7'($urandom_range(1) * 17), 16'($urandom)};
        1: return {8'h6f + 8'($urandom_range(1) * 15), 16'($urandom)};
        2: return {1'($urandom), 7'h3f - 7'($urandom_range(15)), 16'h5fff};
        default: return {1'($urandom), 7'h30 + 7'($urandom_range(15)), 16'h8000};
      endcase
    end
    return 24'($urandom);
  endfunction

  task automatic queue_random(int unsigned count);
    acc_op_t op;
    logic [23:0] addr;
    int tries;
    repeat (count) begin
      op = ($urandom_range(99) < 45) ? ACC_WRITE : ACC_READ;
      addr = pick_address();
      tries = 0;
      while (op == ACC_READ && !readable(addr) && tries < 8) begin
        if (touched_q.size() != 0 && $urandom_range(9) < 7)
          addr = touched_q[$urandom_range(touched_q.size() - 1)];
        else
          addr = pick_address();
        tries++;
      end
      queue_access(op, addr, 8'($urandom));
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || read_bytes_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apply_config(logic locked, logic [22:0] rom, logic [17:0] ram);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= hrm_pkg::CFG_ROM_LOCKED;
    cfg_wdata <= 23'(locked);
    @(negedge clk);
    cfg_index <= hrm_pkg::CFG_ROM_BYTES;
    cfg_wdata <= rom;
    @(negedge clk);
    cfg_index <= hrm_pkg::CFG_RAM_BYTES;
    cfg_wdata <= 23'(ram);
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_locked = locked;
    cfg_rom    = rom;
    cfg_ram    = ram;
  endtask

  // Driver: a presented item stays on the bus until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid  <= 1'b0;
      out_bus.ready <= 1'b0;
    end else begin
      if (!in_busy) begin
        if (pending_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          in_bus.valid       <= 1'b1;
          in_bus.operation   <= pending_q[0].op;
          in_bus.bus_address <= pending_q[0].addr;
          in_bus.write_byte  <= pending_q[0].data;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= calm || $urandom_range(99) >= 10;
    end
  end

  // Monitor: predicts on each accepted access and checks each accepted result.
  always @(posedge clk) begin : monitor
    access_t    acc;
    logic [7:0] want;
    if (!rst_n) begin
      in_busy <= 1'b0;
    end else begin
      in_busy <= in_bus.valid && !in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        if (pending_q.size() == 0) begin
          log_mismatch("access accepted with nothing presented");
        end else begin
          acc = pending_q.pop_front();
          read_bytes_q.push_back(expected_read(acc));
        end
      end
      if (out_bus.valid && out_bus.ready) begin
        if (read_bytes_q.size() == 0) begin
          log_mismatch($sformatf("unexpected result read_byte=%02h", out_bus.read_byte));
        end else begin
          want = read_bytes_q.pop_front();
          if (out_bus.read_byte !== want)
            log_mismatch($sformatf("read_byte=%02h, want %02h", out_bus.read_byte, want));
        end
      end
    end
  end

  initial begin : stimulus
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = hrm_pkg::CFG_ROM_LOCKED;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.operation   = ACC_READ;
    in_bus.bus_address = '0;
    in_bus.write_byte  = '0;
    out_bus.ready      = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset mapping: ROM locked and no RAM, so every access reads zero.
    queue_access(ACC_WRITE, 24'h000000, 8'ha5);
    queue_access(ACC_READ,  24'h306000, 8'h00);
    queue_access(ACC_WRITE, 24'hbf7fff, 8'hff);
    queue_access(ACC_READ,  24'h7dffff, 8'h00);
    drain();

    apply_config(1'b0, 23'h400000, 18'h20000);
    queue_access(ACC_WRITE, 24'h000000, 8'h00);
    queue_access(ACC_WRITE, 24'hffffff, 8'hff);
    queue_access(ACC_WRITE, 24'hf00000, 8'h3c);
    // A window B write must leave the ROM byte with the same low address alone.
    queue_access(ACC_WRITE, 24'h700000, 8'hc3);
    queue_access(ACC_READ,  24'hf00000, 8'h00);
    queue_access(ACC_READ,  24'h700000, 8'h00);
    // The top of window A and the top of window B share a RAM byte.
    queue_access(ACC_WRITE, 24'h3f7fff, 8'h81);
    queue_access(ACC_READ,  24'h7dffff, 8'h00);
    queue_access(ACC_WRITE, 24'hb06000, 8'h5a);
    queue_access(ACC_READ,  24'h700000, 8'h00);
    queue_access(ACC_WRITE, 24'h305fff, 8'h11);
    queue_access(ACC_WRITE, 24'h308000, 8'h22);
    queue_access(ACC_WRITE, 24'h7e0000, 8'h33);
    queue_access(ACC_WRITE, 24'h6fffff, 8'h44);
    queue_access(ACC_READ,  24'hffffff, 8'h00);
    queue_access(ACC_READ,  24'h000000, 8'h00);
    queue_access(ACC_READ,  24'h305fff, 8'h00);
    queue_access(ACC_READ,  24'h308000, 8'h00);
    queue_access(ACC_READ,  24'h7e0000, 8'h00);
    queue_access(ACC_READ,  24'h6fffff, 8'h00);
    queue_random(250);
    drain();

    apply_config(1'b0, 23'h300000, 18'h02000);
    queue_random(250);
    drain();

    // Locked ROM over a split layout, with both sides running flat out.
    calm = 1'b1;
    apply_config(1'b1, 23'h280000, 18'h20000);
    queue_random(250);
    drain();
    calm = 1'b0;

    apply_config(1'b0, 23'h000001, 18'h00002);
    queue_random(150);
    drain();

    // RAM size that is not a power of two; the sender also waits out the pipeline midway.
    apply_config(1'b0, 23'h05a5a5, 18'h06000);
    queue_random(120);
    drain();
    queue_random(130);
    drain();

    apply_config(1'b0, 23'h000000, 18'h00001);
    queue_random(100);
    drain();

    apply_config(1'b1, 23'h400000, 18'h00000);
    queue_random(150);
    drain();

    apply_config(1'b0, 23'h3fffff, 18'h10000);
    queue_random(400);
    drain();
    repeat (6) @(negedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/hrm_pkg.sv
rtl/hrm_if.sv
rtl/hrm_ram.sv
rtl/hrm_cfg.sv
rtl/hirom_cartridge_mapper.sv
rtl/hrm_checker.sv
sim/tb_hirom_cartridge_mapper.sv
